/* rtl/dbec_pkg.sv */
package dbec_pkg;

  localparam int MAX_PINS = 16;
  localparam int PIN_COUNT_DEFAULT = 16;

  localparam logic [1:0] OP_TICK       = 2'd0;
  localparam logic [1:0] OP_READ_COUNT = 2'd1;
  localparam logic [1:0] OP_SET_EDGE   = 2'd2;
  localparam logic [1:0] OP_READ_VALUE = 2'd3;

  localparam logic [1:0] MODE_RISING  = 2'd0;
  localparam logic [1:0] MODE_FALLING = 2'd1;
  localparam logic [1:0] MODE_BOTH    = 2'd2;
  localparam logic [7:0] MODE_LIMIT   = 8'd2;

  localparam logic [1:0] REG_IRQ_ENABLE = 2'd0;
  localparam logic [1:0] REG_HOLDOFF    = 2'd1;
  localparam logic [1:0] REG_PRESENT    = 2'd2;

  localparam logic [7:0]  EDGE_HOLDOFF_RESET = 8'd100;
  localparam logic [31:0] PERIOD_RESET       = 32'd100;
  localparam logic [15:0] PRESENT_RESET      = 16'd15;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  tick_kind;
    logic [15:0] pin_levels;
    logic [7:0]  pin_index;
    logic        clear_after_read;
    logic [15:0] select_mask;
    logic [7:0]  edge_mode;
    logic [7:0]  edge_holdoff;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] count;
    logic [15:0] active_pins;
    logic        change_report;
    logic [15:0] changed_pins;
  } result_t;

  typedef struct packed {
    logic       tick;
    logic       count_pass;
    logic       prime;
    logic       set_en;
    logic [1:0] mode;
    logic [7:0] holdoff;
  } lane_ctl_t;

  typedef struct packed {
    logic tick;
    logic count_pass;
    logic check_pass;
  } chg_ctl_t;

endpackage

/* rtl/debounced_edge_counter_with_change_irq.sv */
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; all pins update in parallel in their lanes.
// The input stalls only while a finished result is held by a stalled output.
// Reset (rst, synchronous, active high) clears counts, hold-offs and the
// change tracker, sets every pin to rising mode with a debounce of 100 ticks.
module debounced_edge_counter_with_change_irq #(
  parameter int PIN_COUNT = dbec_pkg::PIN_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  dbec_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output dbec_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam logic [15:0] PIN_MASK = 16'((33'd1 << PIN_COUNT) - 33'd1);

  logic [15:0] irq_enable;
  logic [31:0] holdoff_period;
  logic [15:0] pin_present;

  logic                accept;
  logic [15:0]         value;
  logic [15:0]         sel;
  logic                mode_ok;
  logic                pin_ok;
  logic                primed;
  logic                report;
  logic [15:0]         changed;
  logic [31:0]         lane_count [PIN_COUNT];
  logic [31:0]         read_count;
  dbec_pkg::lane_ctl_t lane_ctl;
  dbec_pkg::chg_ctl_t  chg_ctl;
  dbec_pkg::result_t   result_next;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable     <= 16'd0;
      holdoff_period <= dbec_pkg::PERIOD_RESET;
      pin_present    <= dbec_pkg::PRESENT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dbec_pkg::REG_IRQ_ENABLE: irq_enable     <= cfg_data[15:0];
        dbec_pkg::REG_HOLDOFF:    holdoff_period <= cfg_data;
        dbec_pkg::REG_PRESENT:    pin_present    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    value   = ~item.pin_levels & pin_present & PIN_MASK;
    sel     = item.select_mask & PIN_MASK;
    mode_ok = item.edge_mode <= dbec_pkg::MODE_LIMIT;
    pin_ok  = 32'(item.pin_index) < PIN_COUNT;

    lane_ctl.tick       = accept && item.op == dbec_pkg::OP_TICK;
    lane_ctl.count_pass = item.tick_kind[0];
    lane_ctl.prime      = !primed;
    lane_ctl.set_en     = accept && item.op == dbec_pkg::OP_SET_EDGE && mode_ok;
    lane_ctl.mode       = item.edge_mode[1:0];
    lane_ctl.holdoff    = item.edge_holdoff;

    chg_ctl.tick       = lane_ctl.tick;
    chg_ctl.count_pass = item.tick_kind[0];
    chg_ctl.check_pass = item.tick_kind[1];

    read_count = 32'd0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (item.pin_index == 8'(i)) begin
        read_count = lane_count[i];
      end
    end
  end

  dbec_change u_change (
    .clk     (clk),
    .rst     (rst),
    .ctl     (chg_ctl),
    .value   (value),
    .enable  (irq_enable & PIN_MASK),
    .period  (holdoff_period),
    .primed  (primed),
    .report  (report),
    .changed (changed)
  );

  for (genvar g = 0; g < PIN_COUNT; g++) begin : g_lane
    dbec_pin_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .active  (value[g]),
      .present (pin_present[g]),
      .sel     (sel[g]),
      .clear   (accept && item.op == dbec_pkg::OP_READ_COUNT
                && item.clear_after_read && item.pin_index == 8'(g)),
      .count   (lane_count[g])
    );
  end

  always_comb begin
    result_next.status        = dbec_pkg::STATUS_OK;
    result_next.count         = 32'd0;
    result_next.active_pins   = value;
    result_next.change_report = 1'b0;
    result_next.changed_pins  = 16'd0;
    unique case (item.op)
      dbec_pkg::OP_TICK: begin
        result_next.change_report = report;
        result_next.changed_pins  = changed;
      end
      dbec_pkg::OP_READ_COUNT: begin
        if (pin_ok) begin
          result_next.count = read_count;
        end else begin
          result_next.status = dbec_pkg::STATUS_INVALID;
        end
      end
      dbec_pkg::OP_SET_EDGE: begin
        if (!mode_ok) begin
          result_next.status = dbec_pkg::STATUS_INVALID;
        end
      end
      dbec_pkg::OP_READ_VALUE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/dbec_pin_lane.sv */
module dbec_pin_lane (
  input  logic                clk,
  input  logic                rst,
  input  dbec_pkg::lane_ctl_t ctl,
  input  logic                active,
  input  logic                present,
  input  logic                sel,
  input  logic                clear,
  output logic [31:0]         count
);

  logic [1:0] mode;
  logic [7:0] holdoff;
  logic [7:0] holdoff_left;
  logic       debounced;

  logic [7:0] holdoff_left_next;
  logic       db_cur;
  logic       hit;
  logic       bump;

  always_comb begin
    holdoff_left_next = (holdoff_left != 8'd0) ? holdoff_left - 8'd1 : holdoff_left;
    db_cur = ctl.prime ? active : debounced;
    hit = (holdoff_left_next == 8'd0) && present && (active != db_cur);
    bump = hit && ((active && (mode == dbec_pkg::MODE_RISING || mode == dbec_pkg::MODE_BOTH))
                || (!active && (mode == dbec_pkg::MODE_FALLING
                                || mode == dbec_pkg::MODE_BOTH)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= 32'd0;
      mode         <= dbec_pkg::MODE_RISING;
      holdoff      <= dbec_pkg::EDGE_HOLDOFF_RESET;
      holdoff_left <= 8'd0;
      debounced    <= 1'b0;
    end else begin
      if (ctl.tick) begin
        if (ctl.count_pass) begin
          holdoff_left <= hit ? holdoff : holdoff_left_next;
          debounced    <= hit ? active : db_cur;
          if (bump) begin
            count <= count + 32'd1;
          end
        end else begin
          debounced <= db_cur;
        end
      end
      if (ctl.set_en && sel) begin
        mode    <= ctl.mode;
        holdoff <= ctl.holdoff;
        count   <= 32'd0;
      end
      if (clear) begin
        count <= 32'd0;
      end
    end
  end

endmodule

/* rtl/dbec_change.sv */
module dbec_change (
  input  logic               clk,
  input  logic               rst,
  input  dbec_pkg::chg_ctl_t ctl,
  input  logic [15:0]        value,
  input  logic [15:0]        enable,
  input  logic [31:0]        period,
  output logic               primed,
  output logic               report,
  output logic [15:0]        changed
);

  logic [31:0] report_holdoff_left;
  logic [15:0] previous_value;

  logic [31:0] report_holdoff_left_next;
  logic [15:0] prev_cur;
  logic        check;

  always_comb begin
    prev_cur = primed ? previous_value : ~value;
    report_holdoff_left_next = report_holdoff_left;
    if (ctl.count_pass && report_holdoff_left != 32'd0) begin
      report_holdoff_left_next = report_holdoff_left - 32'd1;
    end
    check   = ctl.check_pass && (enable != 16'd0) && (report_holdoff_left_next == 32'd0);
    changed = check ? (enable & (value ^ prev_cur)) : 16'd0;
    report  = changed != 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed              <= 1'b0;
      report_holdoff_left <= 32'd0;
      previous_value      <= 16'd0;
    end else if (ctl.tick) begin
      primed              <= 1'b1;
      previous_value      <= check ? value : prev_cur;
      report_holdoff_left <= report ? period : report_holdoff_left_next;
    end
  end

endmodule

/* dv/debounced_edge_counter_with_change_irq_test.sv */
module debounced_edge_counter_with_change_irq_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PINS = dbec_pkg::PIN_COUNT_DEFAULT;
  localparam logic [31:0] LANE_WIDE = (32'd1 << PINS) - 32'd1;
  localparam logic [15:0] LANE_MASK = LANE_WIDE[15:0];
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 400;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = 4;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  dbec_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  dbec_pkg::result_t result;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;

  debounced_edge_counter_with_change_irq uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  typedef struct {
    bit                is_cfg;
    logic [1:0]        cfg_idx;
    logic [31:0]       cfg_val;
    dbec_pkg::item_t   it;
    bit                fixed;
    dbec_pkg::result_t res;
  } row_t;

  row_t              plan[$];
  dbec_pkg::result_t pending_results[$];

  logic              fixed_expect;
  dbec_pkg::result_t fixed_result;

  logic [15:0] irq_mask;
  logic [31:0] quiet_period;
  logic [15:0] present_mask;

  logic [31:0] pin_counts [PINS];
  logic [1:0]  pin_mode [PINS];
  logic [7:0]  pin_debounce [PINS];
  logic [7:0]  pin_wait [PINS];
  logic [15:0] settled;
  logic [31:0] report_wait;
  logic [15:0] last_checked;
  bit          primed;

  int errors;
  int items_sent;
  int results_checked;
  int reports_seen;
  int cfg_writes;
  int idle_cycles;
  int drain_wait;
  bit feed_burst;
  bit drain_burst;

  function automatic dbec_pkg::result_t step_edge_counters(dbec_pkg::item_t it);
    dbec_pkg::result_t r;
    logic [15:0]       act;
    logic [15:0]       diff;
    int                i;
    r = '0;
    act = ~it.pin_levels & present_mask & LANE_MASK;
    r.active_pins = act;
    r.status = dbec_pkg::STATUS_OK;
    case (it.op)
      dbec_pkg::OP_TICK: begin
        if (!primed) begin
          primed = 1'b1;
          settled = act;
          last_checked = ~act;
        end
        if (it.tick_kind[0]) begin
          if (report_wait != 0) report_wait = report_wait - 32'd1;
          for (i = 0; i < PINS; i++) begin
            if (pin_wait[i] != 0) pin_wait[i] = pin_wait[i] - 8'd1;
            if (pin_wait[i] == 0 && present_mask[i] && act[i] != settled[i]) begin
              settled[i] = act[i];
              pin_wait[i] = pin_debounce[i];
              if (act[i] ? (pin_mode[i] != dbec_pkg::MODE_FALLING)
                         : (pin_mode[i] != dbec_pkg::MODE_RISING))
                pin_counts[i] = pin_counts[i] + 32'd1;
            end
          end
        end
        if (it.tick_kind[1] && (irq_mask & LANE_MASK) != 0 && report_wait == 0) begin
          diff = irq_mask & LANE_MASK & (act ^ last_checked);
          last_checked = act;
          if (diff != 0) begin
            r.change_report = 1'b1;
            r.changed_pins = diff;
            report_wait = quiet_period;
          end
        end
      end
      dbec_pkg::OP_READ_COUNT: begin
        if (it.pin_index >= PINS) begin
          r.status = dbec_pkg::STATUS_INVALID;
        end else begin
          r.count = pin_counts[it.pin_index];
          if (it.clear_after_read) pin_counts[it.pin_index] = '0;
        end
      end
      dbec_pkg::OP_SET_EDGE: begin
        if (it.edge_mode > dbec_pkg::MODE_LIMIT) begin
          r.status = dbec_pkg::STATUS_INVALID;
        end else begin
          for (i = 0; i < PINS; i++) begin
            if (it.select_mask[i]) begin
              pin_mode[i] = it.edge_mode[1:0];
              pin_debounce[i] = it.edge_holdoff;
              pin_counts[i] = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic dbec_pkg::item_t pack_item(logic [1:0] op, logic [1:0] kind,
                                                logic [15:0] levels, logic [7:0] pin,
                                                logic clr, logic [15:0] sel,
                                                logic [7:0] mode, logic [7:0] hold);
    dbec_pkg::item_t it;
    it.op = op;
    it.tick_kind = kind;
    it.pin_levels = levels;
    it.pin_index = pin;
    it.clear_after_read = clr;
    it.select_mask = sel;
    it.edge_mode = mode;
    it.edge_holdoff = hold;
    return it;
  endfunction

  function automatic dbec_pkg::result_t pack_result(logic st, logic [31:0] cnt,
                                                    logic [15:0] value, logic rep,
                                                    logic [15:0] changed);
    dbec_pkg::result_t r;
    r.status = st;
    r.count = cnt;
    r.active_pins = value;
    r.change_report = rep;
    r.changed_pins = changed;
    return r;
  endfunction

  task automatic row_cfg(logic [1:0] idx, logic [31:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    plan.push_back(r);
  endtask

  task automatic row_item(dbec_pkg::item_t it);
    row_t r;
    r = '{default: '0};
    r.it = it;
    plan.push_back(r);
  endtask

  task automatic row_fixed(dbec_pkg::item_t it, dbec_pkg::result_t res);
    row_t r;
    r = '{default: '0};
    r.it = it;
    r.fixed = 1'b1;
    r.res = res;
    plan.push_back(r);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic send_item(dbec_pkg::item_t it, bit fixed, dbec_pkg::result_t res);
    int gap;
    if ($urandom_range(0, 31) == 0) feed_burst = !feed_burst;
    gap = feed_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    fixed_expect <= fixed;
    fixed_result <= res;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      dbec_pkg::REG_IRQ_ENABLE: irq_mask = val[15:0];
      dbec_pkg::REG_HOLDOFF:    quiet_period = val;
      dbec_pkg::REG_PRESENT:    present_mask = val[15:0];
      default: begin
      end
    endcase
    cfg_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : drain
    if (result_valid && !result_stall) begin
      if ($urandom_range(0, 31) == 0) drain_burst = !drain_burst;
      drain_wait = drain_burst ? 0 : $urandom_range(0, 16);
    end
    if (drain_wait != 0) begin
      result_stall <= 1'b1;
      drain_wait--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    dbec_pkg::result_t want;
    dbec_pkg::result_t guess;
    bit                moved;
    moved = 1'b0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing outstanding");
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 32'(want.status), 32'(result.status));
          compare_field("count", want.count, result.count);
          compare_field("active_pins", 32'(want.active_pins), 32'(result.active_pins));
          compare_field("change_report", 32'(want.change_report),
                        32'(result.change_report));
          compare_field("changed_pins", 32'(want.changed_pins), 32'(result.changed_pins));
          results_checked++;
          if (want.change_report) reports_seen++;
        end
      end
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        guess = step_edge_counters(item);
        pending_results.push_back(fixed_expect ? fixed_result : guess);
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dbec_pkg::item_t it;
    logic [15:0]     levels;
    int              pick;

    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fixed_expect = 1'b0;
    fixed_result = '0;
    drain_wait = 0;
    irq_mask = '0;
    quiet_period = dbec_pkg::PERIOD_RESET;
    present_mask = dbec_pkg::PRESENT_RESET;
    for (int i = 0; i < PINS; i++) begin
      pin_counts[i] = '0;
      pin_mode[i] = dbec_pkg::MODE_RISING;
      pin_debounce[i] = dbec_pkg::EDGE_HOLDOFF_RESET;
      pin_wait[i] = '0;
    end
    settled = '0;
    report_wait = '0;
    last_checked = '0;
    primed = 1'b0;

    row_fixed(pack_item(dbec_pkg::OP_READ_VALUE, 2'd0, 16'h0000, 8'd0, 1'b0, 16'h0000,
                        8'd0, 8'd0),
              pack_result(dbec_pkg::STATUS_OK, 32'd0, 16'h000F, 1'b0, 16'h0000));
    row_fixed(pack_item(dbec_pkg::OP_READ_COUNT, 2'd0, 16'hFFFF, 8'd0, 1'b1, 16'h0000,
                        8'd0, 8'd0),
              pack_result(dbec_pkg::STATUS_OK, 32'd0, 16'h0000, 1'b0, 16'h0000));
    row_fixed(pack_item(dbec_pkg::OP_READ_COUNT, 2'd0, 16'h5555, 8'd16, 1'b0, 16'h0000,
                        8'd0, 8'd0),
              pack_result(dbec_pkg::STATUS_INVALID, 32'd0, 16'h000A, 1'b0, 16'h0000));
    row_fixed(pack_item(dbec_pkg::OP_READ_COUNT, 2'd3, 16'hFFFF, 8'd255, 1'b1, 16'hFFFF,
                        8'd255, 8'd255),
              pack_result(dbec_pkg::STATUS_INVALID, 32'd0, 16'h0000, 1'b0, 16'h0000));
    row_fixed(pack_item(dbec_pkg::OP_SET_EDGE, 2'd0, 16'hFFFF, 8'd0, 1'b0, 16'hFFFF,
                        8'd3, 8'd7),
              pack_result(dbec_pkg::STATUS_INVALID, 32'd0, 16'h0000, 1'b0, 16'h0000));
    row_fixed(pack_item(dbec_pkg::OP_SET_EDGE, 2'd0, 16'hFFFF, 8'd0, 1'b0, 16'hFFFF,
                        8'd255, 8'd0),
              pack_result(dbec_pkg::STATUS_INVALID, 32'd0, 16'h0000, 1'b0, 16'h0000));
    row_fixed(pack_item(dbec_pkg::OP_SET_EDGE, 2'd0, 16'hFFFF, 8'd0, 1'b0, 16'hFFFF,
                        {6'd0, dbec_pkg::MODE_BOTH}, 8'd0),
              pack_result(dbec_pkg::STATUS_OK, 32'd0, 16'h0000, 1'b0, 16'h0000));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'hFFFF, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd1, 16'h0000, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_READ_COUNT, 2'd0, 16'h0000, 8'd0, 1'b0, 16'h0000,
                       8'd0, 8'd0));
    row_cfg(dbec_pkg::REG_PRESENT, 32'h0000_FFFF);
    row_cfg(dbec_pkg::REG_IRQ_ENABLE, 32'h0000_FFFF);
    row_cfg(dbec_pkg::REG_HOLDOFF, 32'd0);
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'h0000, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd2, 16'h00FF, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd1, 16'hFFFF, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd0, 16'h1234, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'hFFFF, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_READ_COUNT, 2'd0, 16'hFFFF, 8'd15, 1'b1, 16'h0000,
                       8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_SET_EDGE, 2'd0, 16'hFFFF, 8'd0, 1'b0, 16'h00FF,
                       {6'd0, dbec_pkg::MODE_RISING}, 8'd255));
    row_item(pack_item(dbec_pkg::OP_SET_EDGE, 2'd0, 16'hFFFF, 8'd0, 1'b0, 16'hFF00,
                       {6'd0, dbec_pkg::MODE_FALLING}, 8'd1));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'h0000, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'hFFFF, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'h0000, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_READ_COUNT, 2'd0, 16'h0000, 8'd8, 1'b1, 16'h0000,
                       8'd0, 8'd0));
    row_cfg(dbec_pkg::REG_HOLDOFF, 32'hFFFF_FFFF);
    row_cfg(dbec_pkg::REG_IRQ_ENABLE, 32'h0000_0001);
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'hFFFF, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'h0000, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));
    row_cfg(dbec_pkg::REG_PRESENT, 32'h0000_0000);
    row_fixed(pack_item(dbec_pkg::OP_READ_VALUE, 2'd0, 16'h0000, 8'd0, 1'b0, 16'h0000,
                        8'd0, 8'd0),
              pack_result(dbec_pkg::STATUS_OK, 32'd0, 16'h0000, 1'b0, 16'h0000));
    row_item(pack_item(dbec_pkg::OP_TICK, 2'd3, 16'h0000, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].cfg_idx, plan[k].cfg_val);
      else send_item(plan[k].it, plan[k].fixed, plan[k].res);
    end

    levels = 16'hFFFF;
    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(0, 3);
      write_reg(dbec_pkg::REG_IRQ_ENABLE, (pick == 0) ? 32'd0 : (pick == 1) ? 32'h0000_FFFF
                                                      : {16'd0, 16'($urandom)});
      pick = $urandom_range(0, 3);
      write_reg(dbec_pkg::REG_HOLDOFF, (pick == 0) ? 32'd0 : (pick == 1) ? $urandom
                                                   : $urandom_range(0, 6));
      pick = $urandom_range(0, 5);
      write_reg(dbec_pkg::REG_PRESENT, (pick == 0) ? 32'd0 : (pick < 3) ? 32'h0000_FFFF
                                                   : {16'd0, 16'($urandom)});
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if ($urandom_range(0, 15) == 0) levels = 16'($urandom);
        else levels = levels ^ 16'($urandom & $urandom & $urandom);
        pick = $urandom_range(0, 19);
        if (pick < 12) it.op = dbec_pkg::OP_TICK;
        else if (pick < 15) it.op = dbec_pkg::OP_READ_COUNT;
        else if (pick < 17) it.op = dbec_pkg::OP_SET_EDGE;
        else it.op = dbec_pkg::OP_READ_VALUE;
        if ($urandom_range(0, 2) == 0) it.tick_kind = 2'($urandom_range(0, 3));
        else it.tick_kind = 2'd3;
        it.pin_levels = levels;
        if ($urandom_range(0, 7) == 0) it.pin_index = 8'($urandom_range(16, 255));
        else it.pin_index = 8'($urandom_range(0, PINS - 1));
        it.clear_after_read = 1'($urandom_range(0, 1));
        it.select_mask = 16'($urandom & $urandom);
        if ($urandom_range(0, 7) == 0) it.edge_mode = 8'($urandom_range(3, 255));
        else it.edge_mode = 8'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0) it.edge_holdoff = 8'($urandom_range(0, 255));
        else it.edge_holdoff = 8'($urandom_range(0, 4));
        send_item(it, 1'b0, '0);
      end
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions across %0d register writes; checked %0d results.",
             items_sent, cfg_writes, results_checked);
    $display("Change reports observed: %0d.", reports_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
